// File: src/sope_pkg.sv
package sope_pkg;

  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned COORD_W     = 32;
  localparam int unsigned RADII_W     = 64;
  localparam int unsigned NUM_PTS     = 8;
  localparam int unsigned NUM_CORNERS = 4;

  localparam logic [1:0] FUNC_RECT  = 2'd0;
  localparam logic [1:0] FUNC_OVAL  = 2'd1;
  localparam logic [1:0] FUNC_RRECT = 2'd2;

  typedef logic [COORD_W-1:0] coord_t;

  typedef enum logic [1:0] {
    VERB_MOVE  = 2'd0,
    VERB_LINE  = 2'd1,
    VERB_CONIC = 2'd2,
    VERB_CLOSE = 2'd3
  } verb_t;

  typedef enum logic [1:0] {
    MODE_RECT,
    MODE_OVAL,
    MODE_RRECT
  } shape_mode_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MOVE,
    ST_BODY,
    ST_CLOSE
  } seq_state_t;

  // One classified shape. Rectangle and oval outlines repeat their four
  // points in both halves of the point table so the walker can step mod 8.
  typedef struct packed {
    shape_mode_t                mode;
    logic                       ccw;
    logic                       conic_first;
    logic [2:0]                 cur0;
    logic [1:0]                 rc0;
    coord_t                     l;
    coord_t                     t;
    coord_t                     r;
    coord_t                     b;
    logic [NUM_PTS-1:0][COORD_W-1:0] px;
    logic [NUM_PTS-1:0][COORD_W-1:0] py;
  } entry_t;

  typedef struct packed {
    logic   push;
    entry_t data;
  } q_wr_t;

endpackage

// File: src/sope_if.sv
interface sope_in_if;
  logic                             valid;
  logic                             ready;
  logic [1:0]                       func;
  logic                             clockwise_n;
  logic [2:0]                       start_index;
  logic signed [sope_pkg::COORD_W-1:0] left;
  logic signed [sope_pkg::COORD_W-1:0] top;
  logic signed [sope_pkg::COORD_W-1:0] right;
  logic signed [sope_pkg::COORD_W-1:0] bottom;
  logic [sope_pkg::RADII_W-1:0]     upper_left_radii;
  logic [sope_pkg::RADII_W-1:0]     upper_right_radii;
  logic [sope_pkg::RADII_W-1:0]     lower_right_radii;
  logic [sope_pkg::RADII_W-1:0]     lower_left_radii;

  modport source (
    output valid, func, clockwise_n, start_index, left, top, right, bottom,
           upper_left_radii, upper_right_radii, lower_right_radii, lower_left_radii,
    input  ready
  );
  modport sink (
    input  valid, func, clockwise_n, start_index, left, top, right, bottom,
           upper_left_radii, upper_right_radii, lower_right_radii, lower_left_radii,
    output ready
  );
endinterface

interface sope_out_if;
  logic                             valid;
  logic                             ready;
  logic [1:0]                       verb;
  logic signed [sope_pkg::COORD_W-1:0] first_x;
  logic signed [sope_pkg::COORD_W-1:0] first_y;
  logic signed [sope_pkg::COORD_W-1:0] end_x;
  logic signed [sope_pkg::COORD_W-1:0] end_y;
  logic                             last;

  modport source (
    output valid, verb, first_x, first_y, end_x, end_y, last,
    input  ready
  );
  modport sink (
    input  valid, verb, first_x, first_y, end_x, end_y, last,
    output ready
  );
endinterface

// File: src/sope_front.sv
module sope_front (
  input  logic            clk,
  input  logic            rst_n,
  sope_in_if.sink         in_ch,
  input  logic            q_full,
  output sope_pkg::q_wr_t q_wr
);
  import sope_pkg::*;

  logic               stg_valid_r, stg_valid_nxt;
  logic [1:0]         stg_func_r;
  logic               stg_ccw_r;
  logic [2:0]         stg_idx_r;
  coord_t             stg_l_r, stg_t_r, stg_r_r, stg_b_r;
  logic [NUM_CORNERS-1:0][RADII_W-1:0] stg_rad_r;

  logic               accept, func_ok, stg_done;
  logic [COORD_W:0]   w, h, sum_x, sum_y;
  logic               w_pos, h_pos, all_zero, is_oval;
  coord_t             cx, cy;
  coord_t             rect_x [NUM_CORNERS];
  coord_t             rect_y [NUM_CORNERS];
  coord_t             oval_x [NUM_CORNERS];
  coord_t             oval_y [NUM_CORNERS];
  coord_t             rr_x   [NUM_PTS];
  coord_t             rr_y   [NUM_PTS];
  coord_t             rx     [NUM_CORNERS];
  coord_t             ry     [NUM_CORNERS];
  logic [3:0]         idx_p1;
  logic [1:0]         e_idx;
  entry_t             ent;

  assign accept   = in_ch.valid && in_ch.ready;
  assign func_ok  = (stg_func_r == FUNC_RECT) || (stg_func_r == FUNC_OVAL) ||
                    (stg_func_r == FUNC_RRECT);
  // unused shape kind is dropped without producing anything
  assign stg_done = stg_valid_r && (!func_ok || !q_full);
  assign in_ch.ready = !stg_valid_r || stg_done;

  assign q_wr.push = stg_valid_r && func_ok && !q_full;
  assign q_wr.data = ent;

  always_comb begin
    stg_valid_nxt = stg_valid_r;
    if (accept) begin
      stg_valid_nxt = 1'b1;
    end else if (stg_done) begin
      stg_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stg_valid_r <= 1'b0;
    end else begin
      stg_valid_r <= stg_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      stg_func_r   <= in_ch.func;
      stg_ccw_r    <= in_ch.clockwise_n;
      stg_idx_r    <= in_ch.start_index;
      stg_l_r      <= in_ch.left;
      stg_t_r      <= in_ch.top;
      stg_r_r      <= in_ch.right;
      stg_b_r      <= in_ch.bottom;
      stg_rad_r[0] <= in_ch.upper_left_radii;
      stg_rad_r[1] <= in_ch.upper_right_radii;
      stg_rad_r[2] <= in_ch.lower_right_radii;
      stg_rad_r[3] <= in_ch.lower_left_radii;
    end
  end

  // exact 33-bit extents and centers
  always_comb begin
    w     = {stg_r_r[COORD_W-1], stg_r_r} - {stg_l_r[COORD_W-1], stg_l_r};
    h     = {stg_b_r[COORD_W-1], stg_b_r} - {stg_t_r[COORD_W-1], stg_t_r};
    sum_x = {stg_l_r[COORD_W-1], stg_l_r} + {stg_r_r[COORD_W-1], stg_r_r};
    sum_y = {stg_t_r[COORD_W-1], stg_t_r} + {stg_b_r[COORD_W-1], stg_b_r};
    cx    = sum_x[COORD_W:1];
    cy    = sum_y[COORD_W:1];
    w_pos = !w[COORD_W] && (w != '0);
    h_pos = !h[COORD_W] && (h != '0);
  end

  always_comb begin
    all_zero = 1'b1;
    is_oval  = 1'b1;
    for (int k = 0; k < NUM_CORNERS; k++) begin
      rx[k] = stg_rad_r[k][COORD_W-1:0];
      ry[k] = stg_rad_r[k][RADII_W-1:COORD_W];
      if (rx[k] != '0 || ry[k] != '0) begin
        all_zero = 1'b0;
      end
      if ({rx[k], 1'b0} != w || {ry[k], 1'b0} != h) begin
        is_oval = 1'b0;
      end
    end
  end

  always_comb begin
    rect_x[0] = stg_l_r; rect_y[0] = stg_t_r;
    rect_x[1] = stg_r_r; rect_y[1] = stg_t_r;
    rect_x[2] = stg_r_r; rect_y[2] = stg_b_r;
    rect_x[3] = stg_l_r; rect_y[3] = stg_b_r;
    oval_x[0] = cx;      oval_y[0] = stg_t_r;
    oval_x[1] = stg_r_r; oval_y[1] = cy;
    oval_x[2] = cx;      oval_y[2] = stg_b_r;
    oval_x[3] = stg_l_r; oval_y[3] = cy;
    rr_x[0] = stg_l_r + rx[0]; rr_y[0] = stg_t_r;
    rr_x[1] = stg_r_r - rx[1]; rr_y[1] = stg_t_r;
    rr_x[2] = stg_r_r;         rr_y[2] = stg_t_r + ry[1];
    rr_x[3] = stg_r_r;         rr_y[3] = stg_b_r - ry[2];
    rr_x[4] = stg_r_r - rx[2]; rr_y[4] = stg_b_r;
    rr_x[5] = stg_l_r + rx[3]; rr_y[5] = stg_b_r;
    rr_x[6] = stg_l_r;         rr_y[6] = stg_b_r - ry[3];
    rr_x[7] = stg_l_r;         rr_y[7] = stg_t_r + ry[0];
  end

  always_comb begin
    idx_p1          = {1'b0, stg_idx_r} + 4'd1;
    e_idx           = stg_idx_r[1:0];
    ent.mode        = MODE_RECT;
    ent.ccw         = stg_ccw_r;
    ent.conic_first = stg_idx_r[0] ^ stg_ccw_r;
    ent.l           = stg_l_r;
    ent.t           = stg_t_r;
    ent.r           = stg_r_r;
    ent.b           = stg_b_r;
    case (stg_func_r)
      FUNC_OVAL: begin
        ent.mode = MODE_OVAL;
      end
      FUNC_RRECT: begin
        if (!w_pos || !h_pos || all_zero) begin
          ent.mode = MODE_RECT;
          e_idx    = idx_p1[2:1];
        end else if (is_oval) begin
          ent.mode = MODE_OVAL;
          e_idx    = stg_idx_r[2:1];
        end else begin
          ent.mode = MODE_RRECT;
        end
      end
      default: begin
        ent.mode = MODE_RECT;
      end
    endcase

    if (ent.mode == MODE_RRECT) begin
      ent.cur0 = stg_idx_r;
      ent.rc0  = stg_idx_r[2:1] + {1'b0, stg_ccw_r};
    end else begin
      ent.cur0 = {1'b0, e_idx};
      ent.rc0  = e_idx + {1'b0, stg_ccw_r};
    end

    for (int i = 0; i < NUM_PTS; i++) begin
      case (ent.mode)
        MODE_OVAL: begin
          ent.px[i] = oval_x[i % NUM_CORNERS];
          ent.py[i] = oval_y[i % NUM_CORNERS];
        end
        MODE_RRECT: begin
          ent.px[i] = rr_x[i];
          ent.py[i] = rr_y[i];
        end
        default: begin
          ent.px[i] = rect_x[i % NUM_CORNERS];
          ent.py[i] = rect_y[i % NUM_CORNERS];
        end
      endcase
    end
  end

endmodule

// File: src/sope_queue.sv
module sope_queue #(
  parameter int unsigned Depth = sope_pkg::QUEUE_DEPTH
) (
  input  logic             clk,
  input  logic             rst_n,
  input  sope_pkg::q_wr_t  q_wr,
  input  logic             pop,
  output logic             full,
  output logic             q_valid,
  output sope_pkg::entry_t q_data
);
  import sope_pkg::*;

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  entry_t            mem_r [Depth];
  logic [PtrW-1:0]   wr_ptr_r, rd_ptr_r;
  logic [CntW-1:0]   cnt_r, cnt_nxt;

  assign full    = (cnt_r == CntW'(Depth));
  assign q_valid = (cnt_r != '0);
  assign q_data  = mem_r[rd_ptr_r];

  always_comb begin
    cnt_nxt = cnt_r;
    if (q_wr.push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !q_wr.push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      cnt_r <= cnt_nxt;
      if (q_wr.push) begin
        wr_ptr_r <= (wr_ptr_r == PtrW'(Depth - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == PtrW'(Depth - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_wr.push) begin
      mem_r[wr_ptr_r] <= q_wr.data;
    end
  end

`ifndef NO_ASSERTIONS
  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
    q_wr.push |-> !full) else $error("push into full queue");
  a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> cnt_r != '0) else $error("pop from empty queue");
`endif

endmodule

// File: src/sope_back.sv
module sope_back (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             q_valid,
  input  sope_pkg::entry_t q_data,
  output logic             q_pop,
  sope_out_if.source       out_ch
);
  import sope_pkg::*;

  seq_state_t state_r, state_nxt;
  entry_t     ent_r;
  logic [2:0] cur_r, cur_nxt, cur_step, adv8;
  logic [1:0] rc_r, rc_nxt, rc_step, adv4;
  logic [1:0] cnt_r, cnt_nxt;
  logic       line_next_r, line_next_nxt;

  logic       out_valid_r;
  verb_t      out_verb_r;
  coord_t     out_fx_r, out_fy_r, out_ex_r, out_ey_r;
  logic       out_last_r;

  verb_t      cmd_verb;
  coord_t     cmd_fx, cmd_fy, cmd_ex, cmd_ey;
  logic       cmd_last;

  logic       advance, body_line, body_last;

  assign advance   = (state_r != ST_IDLE) && (!out_valid_r || out_ch.ready);
  assign q_pop     = q_valid && ((state_r == ST_IDLE) || (state_r == ST_CLOSE && advance));
  assign adv8      = ent_r.ccw ? 3'd7 : 3'd1;
  assign adv4      = ent_r.ccw ? 2'd3 : 2'd1;
  assign cur_step  = cur_r + adv8;
  assign rc_step   = rc_r + adv4;
  assign body_line = (ent_r.mode == MODE_RECT) || (ent_r.mode == MODE_RRECT && line_next_r);
  // rectangle ends after its third line, the others after their fourth conic
  assign body_last = body_line ? (ent_r.mode == MODE_RECT && cnt_r == 2'd2)
                               : (cnt_r == 2'd3);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:  if (q_valid) state_nxt = ST_MOVE;
      ST_MOVE:  if (advance) state_nxt = ST_BODY;
      ST_BODY:  if (advance && body_last) state_nxt = ST_CLOSE;
      ST_CLOSE: if (advance) state_nxt = q_valid ? ST_MOVE : ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_verb      = VERB_CLOSE;
    cmd_fx        = '0;
    cmd_fy        = '0;
    cmd_ex        = '0;
    cmd_ey        = '0;
    cmd_last      = 1'b0;
    cur_nxt       = cur_r;
    rc_nxt        = rc_r;
    cnt_nxt       = cnt_r;
    line_next_nxt = line_next_r;
    unique case (state_r)
      ST_MOVE: begin
        cmd_verb = VERB_MOVE;
        cmd_fx   = ent_r.px[cur_r];
        cmd_fy   = ent_r.py[cur_r];
      end
      ST_BODY: begin
        cur_nxt       = cur_step;
        line_next_nxt = !line_next_r;
        if (body_line) begin
          cmd_verb = VERB_LINE;
          cmd_fx   = ent_r.px[cur_step];
          cmd_fy   = ent_r.py[cur_step];
          if (ent_r.mode == MODE_RECT) begin
            cnt_nxt = cnt_r + 1'b1;
          end
        end else begin
          cmd_verb = VERB_CONIC;
          // control point is the bounding-box corner
          cmd_fx   = (rc_step == 2'd0 || rc_step == 2'd3) ? ent_r.l : ent_r.r;
          cmd_fy   = rc_step[1] ? ent_r.b : ent_r.t;
          cmd_ex   = ent_r.px[cur_step];
          cmd_ey   = ent_r.py[cur_step];
          rc_nxt   = rc_step;
          cnt_nxt  = cnt_r + 1'b1;
        end
      end
      ST_CLOSE: begin
        cmd_verb = VERB_CLOSE;
        cmd_last = 1'b1;
      end
      default: begin
        cmd_verb = VERB_CLOSE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (advance) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      ent_r       <= q_data;
      cur_r       <= q_data.cur0;
      rc_r        <= q_data.rc0;
      cnt_r       <= 2'd0;
      line_next_r <= (q_data.mode == MODE_RRECT) && !q_data.conic_first;
    end else if (advance) begin
      cur_r       <= cur_nxt;
      rc_r        <= rc_nxt;
      cnt_r       <= cnt_nxt;
      line_next_r <= line_next_nxt;
    end
    if (advance) begin
      out_verb_r <= cmd_verb;
      out_fx_r   <= cmd_fx;
      out_fy_r   <= cmd_fy;
      out_ex_r   <= cmd_ex;
      out_ey_r   <= cmd_ey;
      out_last_r <= cmd_last;
    end
  end

  assign out_ch.valid   = out_valid_r;
  assign out_ch.verb    = out_verb_r;
  assign out_ch.first_x = out_fx_r;
  assign out_ch.first_y = out_fy_r;
  assign out_ch.end_x   = out_ex_r;
  assign out_ch.end_y   = out_ey_r;
  assign out_ch.last    = out_last_r;

`ifndef NO_ASSERTIONS
  a_pop_at_boundary: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> (state_r == ST_IDLE || state_r == ST_CLOSE))
    else $error("queue popped in the middle of a shape");
  a_last_is_close: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_last_r |-> out_verb_r == VERB_CLOSE)
    else $error("last flag on a non-close command");
  a_body_to_close: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_BODY && advance && body_last) |=> (state_r == ST_CLOSE && out_valid_r))
    else $error("body did not end in close");
`endif

endmodule

// File: src/shape_outline_path_emitter_unit.sv
// Channel | Dir | Transaction
// in_ch   | in  | one shape: kind, direction, start index, bounds, four corner radii
// out_ch  | out | one path command: verb, first point, conic end point, last flag
//
// A shape produces 5 (rectangle), 6 (oval), 9 or 10 (rounded rectangle) commands,
// one per cycle from the back-end sequencer while out_ch is not stalled.
// A shape passes the staging register, shape queue, sequencer entry and output register.
// The queue lets new shapes be classified while the sequencer works on an earlier one.
// Reset is synchronous and active low; it empties the staging register, queue and output.
// A stall on out_ch holds the sequencer; in_ch backs up only once the queue is full.
module shape_outline_path_emitter_unit #(
  parameter int unsigned QueueDepth = sope_pkg::QUEUE_DEPTH
) (
  input logic        clk,
  input logic        rst_n,
  sope_in_if.sink    in_ch,
  sope_out_if.source out_ch
);
  import sope_pkg::*;

  q_wr_t  q_wr;
  logic   q_full, q_valid, q_pop;
  entry_t q_data;

  sope_front u_front (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .q_full (q_full),
    .q_wr   (q_wr)
  );

  sope_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_wr    (q_wr),
    .pop     (q_pop),
    .full    (q_full),
    .q_valid (q_valid),
    .q_data  (q_data)
  );

  sope_back u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_valid (q_valid),
    .q_data  (q_data),
    .q_pop   (q_pop),
    .out_ch  (out_ch)
  );

endmodule

// File: tb/tb_shape_outline_path_emitter_unit.sv
`timescale 1ns / 1ps

import sope_pkg::*;

localparam logic [1:0] FUNC_UNUSED = 2'd3;

typedef struct {
  logic [1:0]       func;
  logic             ccw;
  logic [2:0]       idx;
  coord_t           left;
  coord_t           top;
  coord_t           right;
  coord_t           bottom;
  logic [3:0][63:0] radii;  // upper-left, upper-right, lower-right, lower-left
} shape_item_t;

typedef struct {
  logic [1:0] verb;
  coord_t     fx;
  coord_t     fy;
  coord_t     ex;
  coord_t     ey;
  logic       last;
} path_cmd_t;

class outline_scoreboard;
  path_cmd_t   due_cmds[$];
  int unsigned errors;

  function new();
    errors = 0;
  endfunction

  function int pending();
    return due_cmds.size();
  endfunction

  function void push_cmd(verb_t v, coord_t fx, coord_t fy, coord_t ex, coord_t ey, logic last);
    path_cmd_t c;
    c.verb = v;
    c.fx   = fx;
    c.fy   = fy;
    c.ex   = ex;
    c.ey   = ey;
    c.last = last;
    due_cmds.insert(due_cmds.size(), c);
  endfunction

  function void rect_outline(coord_t l, coord_t t, coord_t r, coord_t b, logic ccw, int idx);
    coord_t xs[4];
    coord_t ys[4];
    int     cur;
    int     step;
    xs   = '{l, r, r, l};
    ys   = '{t, t, b, b};
    cur  = idx & 3;
    step = ccw ? 3 : 1;
    push_cmd(VERB_MOVE, xs[cur], ys[cur], '0, '0, 1'b0);
    for (int i = 0; i < 3; i++) begin
      cur = (cur + step) & 3;
      push_cmd(VERB_LINE, xs[cur], ys[cur], '0, '0, 1'b0);
    end
    push_cmd(VERB_CLOSE, '0, '0, '0, '0, 1'b1);
  endfunction

  function void oval_outline(coord_t l, coord_t t, coord_t r, coord_t b, logic ccw, int idx);
    logic signed [32:0] sx;
    logic signed [32:0] sy;
    coord_t             cx;
    coord_t             cy;
    coord_t             kx[4];
    coord_t             ky[4];
    coord_t             ox[4];
    coord_t             oy[4];
    int                 oc;
    int                 rc;
    int                 step;
    // midpoints floor the exact 33-bit sum
    sx   = {l[31], l} + {r[31], r};
    sy   = {t[31], t} + {b[31], b};
    cx   = sx[32:1];
    cy   = sy[32:1];
    kx   = '{l, r, r, l};
    ky   = '{t, t, b, b};
    ox   = '{cx, r, cx, l};
    oy   = '{t, cy, b, cy};
    oc   = idx & 3;
    rc   = (idx + int'(ccw)) & 3;
    step = ccw ? 3 : 1;
    push_cmd(VERB_MOVE, ox[oc], oy[oc], '0, '0, 1'b0);
    for (int i = 0; i < 4; i++) begin
      rc = (rc + step) & 3;
      oc = (oc + step) & 3;
      push_cmd(VERB_CONIC, kx[rc], ky[rc], ox[oc], oy[oc], 1'b0);
    end
    push_cmd(VERB_CLOSE, '0, '0, '0, '0, 1'b1);
  endfunction

  function void queue_outline(shape_item_t s);
    coord_t rx[4];
    coord_t ry[4];
    coord_t px[8];
    coord_t py[8];
    coord_t kx[4];
    coord_t ky[4];
    longint w;
    longint h;
    bit     all_zero;
    bit     is_oval;
    bit     conic_first;
    int     idx;
    int     cur;
    int     rc;
    int     step8;
    int     step4;
    idx = int'(s.idx);
    case (s.func)
      FUNC_RECT: rect_outline(s.left, s.top, s.right, s.bottom, s.ccw, idx);
      FUNC_OVAL: oval_outline(s.left, s.top, s.right, s.bottom, s.ccw, idx);
      FUNC_RRECT: begin
        w = longint'($signed(s.right)) - longint'($signed(s.left));
        h = longint'($signed(s.bottom)) - longint'($signed(s.top));
        all_zero = 1'b1;
        is_oval  = 1'b1;
        for (int k = 0; k < 4; k++) begin
          rx[k] = s.radii[k][31:0];
          ry[k] = s.radii[k][63:32];
          if (rx[k] != 0 || ry[k] != 0) all_zero = 1'b0;
          if (longint'(rx[k]) * 2 != w || longint'(ry[k]) * 2 != h) is_oval = 1'b0;
        end
        if (w <= 0 || h <= 0 || all_zero) begin
          rect_outline(s.left, s.top, s.right, s.bottom, s.ccw, (idx + 1) / 2);
        end else if (is_oval) begin
          oval_outline(s.left, s.top, s.right, s.bottom, s.ccw, idx / 2);
        end else begin
          px = '{s.left + rx[0], s.right - rx[1], s.right, s.right,
                 s.right - rx[2], s.left + rx[3], s.left, s.left};
          py = '{s.top, s.top, s.top + ry[1], s.bottom - ry[2],
                 s.bottom, s.bottom, s.bottom - ry[3], s.top + ry[0]};
          kx = '{s.left, s.right, s.right, s.left};
          ky = '{s.top, s.top, s.bottom, s.bottom};
          conic_first = ((idx & 1) == (s.ccw ? 0 : 1));
          cur   = idx & 7;
          step8 = s.ccw ? 7 : 1;
          rc    = (idx / 2 + int'(s.ccw)) & 3;
          step4 = s.ccw ? 3 : 1;
          push_cmd(VERB_MOVE, px[cur], py[cur], '0, '0, 1'b0);
          for (int i = 0; i < 4; i++) begin
            if (!conic_first) begin
              cur = (cur + step8) & 7;
              push_cmd(VERB_LINE, px[cur], py[cur], '0, '0, 1'b0);
            end
            rc  = (rc + step4) & 3;
            cur = (cur + step8) & 7;
            push_cmd(VERB_CONIC, kx[rc], ky[rc], px[cur], py[cur], 1'b0);
            if (conic_first && i < 3) begin
              cur = (cur + step8) & 7;
              push_cmd(VERB_LINE, px[cur], py[cur], '0, '0, 1'b0);
            end
          end
          push_cmd(VERB_CLOSE, '0, '0, '0, '0, 1'b1);
        end
      end
      default: ;  // unused kind: block drops the shape
    endcase
  endfunction

  task report(string msg);
    errors++;
    if (errors <= 40) $display("%0t: %s", $realtime, msg);
  endtask

  task check_command(path_cmd_t got);
    path_cmd_t want;
    if (due_cmds.size() == 0) begin
      report($sformatf("command with none due: verb %0d (%h,%h) (%h,%h) last %b",
                       got.verb, got.fx, got.fy, got.ex, got.ey, got.last));
      return;
    end
    want = due_cmds.pop_front();
    if (got.verb !== want.verb || got.fx !== want.fx || got.fy !== want.fy ||
        got.ex !== want.ex || got.ey !== want.ey || got.last !== want.last) begin
      report($sformatf("got verb %0d (%h,%h) (%h,%h) last %b, want verb %0d (%h,%h) (%h,%h) last %b",
                       got.verb, got.fx, got.fy, got.ex, got.ey, got.last,
                       want.verb, want.fx, want.fy, want.ex, want.ey, want.last));
    end
  endtask
endclass

module tb_shape_outline_path_emitter_unit;

  localparam int unsigned CYCLE_LIMIT  = 200000;
  localparam int unsigned RANDOM_ITEMS = 250;

  localparam coord_t C_MIN = 32'h8000_0000;
  localparam coord_t C_MAX = 32'h7FFF_FFFF;
  localparam coord_t BL    = 32'h0001_0000;
  localparam coord_t BT    = 32'h0002_0000;
  localparam coord_t BR    = 32'h0041_0000;
  localparam coord_t BB    = 32'h0032_0000;
  localparam logic [63:0] RAD_UL   = {32'h0004_0000, 32'h0003_0000};
  localparam logic [63:0] RAD_UR   = {32'h0002_8000, 32'h0005_0000};
  localparam logic [63:0] RAD_LR   = {32'h0001_0000, 32'h0000_4000};
  localparam logic [63:0] RAD_LL   = {32'h0006_0000, 32'h0002_0000};
  localparam logic [63:0] RAD_HALF = {32'h0018_0000, 32'h0020_0000};
  localparam logic [63:0] RAD_ONES = '1;

  logic clk = 1'b0;
  logic rst_n;

  logic        tx_idle_on;
  logic        rx_idle_on;
  logic        hold_req;
  int unsigned cycle_count;

  outline_scoreboard sb;

  sope_in_if  in_ch ();
  sope_out_if out_ch ();

  shape_outline_path_emitter_unit u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("tb_shape_outline_path_emitter_unit: done, errors");
      $finish;
    end
  end

  always @(posedge clk) begin : result_monitor
    path_cmd_t got;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      got.verb = out_ch.verb;
      got.fx   = out_ch.first_x;
      got.fy   = out_ch.first_y;
      got.ex   = out_ch.end_x;
      got.ey   = out_ch.end_y;
      got.last = out_ch.last;
      sb.check_command(got);
    end
  end

  // result side: random stall bursts, plus one long hold-off on request
  initial begin : result_sink
    int unsigned stall;
    bit          hold_seen;
    stall = 0;
    hold_seen = 1'b0;
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req && !hold_seen) begin
        hold_seen = 1'b1;
        stall = 300;
      end else if (stall == 0 && rx_idle_on && $urandom_range(0, 4) == 0) begin
        stall = $urandom_range(1, 6);
      end
      if (stall != 0) begin
        out_ch.ready = 1'b0;
        stall--;
      end else begin
        out_ch.ready = 1'b1;
      end
    end
  end

  function automatic shape_item_t make_shape(logic [1:0] func, logic ccw, logic [2:0] idx,
                                             coord_t l, coord_t t, coord_t r, coord_t b,
                                             logic [63:0] ul, logic [63:0] ur,
                                             logic [63:0] lr, logic [63:0] ll);
    shape_item_t s;
    s.func   = func;
    s.ccw    = ccw;
    s.idx    = idx;
    s.left   = l;
    s.top    = t;
    s.right  = r;
    s.bottom = b;
    s.radii  = {ll, lr, ur, ul};
    return s;
  endfunction

  function automatic coord_t rand_origin();
    return coord_t'($urandom_range(0, 32'h7FFF_FFFF)) - 32'h4000_0000;
  endfunction

  function automatic shape_item_t random_shape();
    shape_item_t s;
    int unsigned pick;
    int unsigned bmode;
    int unsigned rmode;
    int unsigned w;
    int unsigned h;
    pick   = $urandom_range(0, 99);
    s.func = (pick < 25) ? FUNC_RECT : (pick < 45) ? FUNC_OVAL :
             (pick < 95) ? FUNC_RRECT : FUNC_UNUSED;
    s.ccw  = 1'($urandom_range(0, 1));
    s.idx  = 3'($urandom_range(0, 7));
    for (int k = 0; k < 4; k++) s.radii[k] = {$urandom, $urandom};
    w     = $urandom_range(2, 1 << 20);
    h     = $urandom_range(2, 1 << 20);
    bmode = $urandom_range(0, 9);
    if (bmode == 0) begin
      s.left   = $urandom;
      s.top    = $urandom;
      s.right  = $urandom;
      s.bottom = $urandom;
      return s;
    end
    s.left = rand_origin();
    s.top  = rand_origin();
    if (s.func == FUNC_RRECT && bmode >= 3) begin
      rmode = $urandom_range(0, 9);
      if (rmode == 1) begin
        w = w & ~32'd1;
        h = h & ~32'd1;
      end
    end else begin
      rmode = 2;
    end
    s.right  = (bmode == 1) ? s.left - $urandom_range(0, 1000) : s.left + w;
    s.bottom = (bmode == 2) ? s.top - $urandom_range(0, 1000) : s.top + h;
    case (rmode)
      0: s.radii = '0;
      1: for (int k = 0; k < 4; k++) s.radii[k] = {h / 2, w / 2};
      2: ;
      default: begin
        for (int k = 0; k < 4; k++) begin
          if ($urandom_range(0, 3) == 0) s.radii[k] = '0;
          else s.radii[k] = {$urandom_range(0, h / 2), $urandom_range(0, w / 2)};
        end
      end
    endcase
    return s;
  endfunction

  task automatic send_shape(shape_item_t s);
    int unsigned gap;
    @(negedge clk);
    in_ch.valid             = 1'b1;
    in_ch.func              = s.func;
    in_ch.clockwise_n       = s.ccw;
    in_ch.start_index       = s.idx;
    in_ch.left              = s.left;
    in_ch.top               = s.top;
    in_ch.right             = s.right;
    in_ch.bottom            = s.bottom;
    in_ch.upper_left_radii  = s.radii[0];
    in_ch.upper_right_radii = s.radii[1];
    in_ch.lower_right_radii = s.radii[2];
    in_ch.lower_left_radii  = s.radii[3];
    do @(posedge clk); while (!in_ch.ready);
    sb.queue_outline(s);
    if (tx_idle_on && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 6);
      @(negedge clk);
      in_ch.valid = 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
  endtask

  initial begin
    shape_item_t s;
    int unsigned shapes_sent;
    sb          = new();
    cycle_count = 0;
    tx_idle_on  = 1'b1;
    rx_idle_on  = 1'b1;
    hold_req    = 1'b0;
    rst_n       = 1'b0;
    in_ch.valid             = 1'b0;
    in_ch.func              = FUNC_RECT;
    in_ch.clockwise_n       = 1'b0;
    in_ch.start_index       = '0;
    in_ch.left              = '0;
    in_ch.top               = '0;
    in_ch.right             = '0;
    in_ch.bottom            = '0;
    in_ch.upper_left_radii  = '0;
    in_ch.upper_right_radii = '0;
    in_ch.lower_right_radii = '0;
    in_ch.lower_left_radii  = '0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // rounded rectangles: all start indexes, both directions, both parities
    for (int i = 0; i < 8; i++) begin
      send_shape(make_shape(FUNC_RRECT, i >= 4, 3'(i), BL, BT, BR, BB,
                            RAD_UL, RAD_UR, RAD_LR, RAD_LL));
    end
    send_shape(make_shape(FUNC_RECT, 1'b0, 3'd1, C_MIN, C_MIN, C_MAX, C_MAX,
                          RAD_ONES, RAD_ONES, RAD_ONES, RAD_ONES));
    send_shape(make_shape(FUNC_RECT, 1'b1, 3'd6, C_MAX, '0, C_MIN, '1, '0, '0, '0, '0));
    // oval center rounds toward minus infinity
    send_shape(make_shape(FUNC_OVAL, 1'b0, 3'd0, -32'sd3, -32'sd7, '0, 32'd4,
                          '0, '0, '0, '0));
    send_shape(make_shape(FUNC_OVAL, 1'b1, 3'd3, C_MIN, C_MIN, C_MAX, C_MAX,
                          '0, '0, '0, '0));
    send_shape(make_shape(FUNC_OVAL, 1'b1, 3'd6, C_MAX, C_MAX, C_MAX, C_MAX,
                          RAD_ONES, '0, RAD_ONES, '0));
    // rounded rectangle falling back to a plain rectangle
    send_shape(make_shape(FUNC_RRECT, 1'b1, 3'd3, BL, BT, BR, BB, '0, '0, '0, '0));
    send_shape(make_shape(FUNC_RRECT, 1'b0, 3'd7, BL, BT, BR, BB, '0, '0, '0, '0));
    send_shape(make_shape(FUNC_RRECT, 1'b0, 3'd2, BL, BT, BL, BB,
                          RAD_UL, RAD_UR, RAD_LR, RAD_LL));
    send_shape(make_shape(FUNC_RRECT, 1'b1, 3'd5, BL, BB, BR, BT,
                          RAD_UL, RAD_UR, RAD_LR, RAD_LL));
    // radii exactly half the size: becomes an oval; the third has one corner off and stays a rounded rectangle
    send_shape(make_shape(FUNC_RRECT, 1'b0, 3'd5, BL, BT, BR, BB,
                          RAD_HALF, RAD_HALF, RAD_HALF, RAD_HALF));
    send_shape(make_shape(FUNC_RRECT, 1'b1, 3'd2, BL, BT, BR, BB,
                          RAD_HALF, RAD_HALF, RAD_HALF, RAD_HALF));
    send_shape(make_shape(FUNC_RRECT, 1'b0, 3'd4, BL, BT, BR, BB,
                          RAD_HALF, RAD_HALF, RAD_HALF, RAD_UL));
    // huge radii wrap the coordinates
    send_shape(make_shape(FUNC_RRECT, 1'b1, 3'd1, BL, BT, BR, BB,
                          RAD_ONES, RAD_ONES, RAD_ONES, RAD_ONES));
    send_shape(make_shape(FUNC_UNUSED, 1'b1, 3'd7, C_MAX, C_MAX, C_MIN, C_MIN,
                          RAD_ONES, RAD_ONES, RAD_ONES, RAD_ONES));

    shapes_sent = 0;
    while (shapes_sent < RANDOM_ITEMS) begin
      if (shapes_sent == 60) hold_req = 1'b1;
      if (shapes_sent == 200) begin
        tx_idle_on = 1'b0;
        rx_idle_on = 1'b0;
      end
      s = random_shape();
      send_shape(s);
      if (s.func != FUNC_UNUSED) shapes_sent++;
    end
    @(negedge clk);
    in_ch.valid = 1'b0;

    while (sb.pending() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("tb_shape_outline_path_emitter_unit: done, clean");
    end else begin
      $display("tb_shape_outline_path_emitter_unit: done, errors");
    end
    $finish;
  end

endmodule
